FILE: hw/rtl/mcs_queue_lock_manager_macros.svh
// assertion macros shared by the lock manager rtl
`ifndef MCS_QUEUE_LOCK_MANAGER_MACROS_SVH
`define MCS_QUEUE_LOCK_MANAGER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MQLM_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("lock manager check failed");

// next-cycle implication, disabled during reset
`define MQLM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("lock manager check failed");

`endif

FILE: hw/rtl/mqlm_pkg.sv
package mqlm_pkg;

   localparam int NODES  = 64;
   localparam int NODE_W = 6;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [2:0] ST_GRANTED = 3'd0;
   localparam logic [2:0] ST_QUEUED  = 3'd1;
   localparam logic [2:0] ST_HANDED  = 3'd2;
   localparam logic [2:0] ST_FREED   = 3'd3;
   localparam logic [2:0] ST_ERROR   = 3'd4;

   typedef logic [NODE_W-1:0] node_type;

   typedef struct packed {
      logic [2:0] status;
      logic       grant_valid;
      node_type   grant_node;
   } result_type;

endpackage

FILE: hw/rtl/mcs_queue_lock_manager.sv
// central mcs queue lock manager, one item in and one result item out per operation
// result: rsp_tvalid rises once an accepted item has passed the execute register and
//    then the output register
// throughput: one item per cycle while rsp_tready stays high; the successor memory is
//    read on acceptance and the execute step then updates the lock state
// stalls: a held result keeps the next item in the execute stage and drops req_tready
// reset: synchronous, active high; clears the queue, successor valid bits and queued marks
`include "mcs_queue_lock_manager_macros.svh"

module mcs_queue_lock_manager (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [5:0] requester, [7:6] zero
   input  logic [mqlm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] kind
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] status, [3] grant_valid, [9:4] grant_node, [15:10] zero
   output logic [mqlm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import mqlm_pkg::*;

   // successor table: node index -> node linked behind it
   node_type   succ_mem [NODES];

   // item held for the execute step
   logic       busy_ff, busy_in;
   logic       kind_ff;
   node_type   node_ff;

   // registered memory read with write forwarding
   node_type   mem_rd_ff;
   logic       fwd_ff, fwd_in;
   node_type   fwd_data_ff;
   node_type   succ_rd;

   // lock state
   logic       tail_valid_ff, tail_valid_in;
   node_type   tail_node_ff, tail_node_in;
   node_type   holder_ff, holder_in;
   logic [NODES-1:0] succ_valid_ff, succ_valid_in;
   logic [NODES-1:0] queued_ff, queued_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       req_fire;
   logic       exec_fire;
   node_type   req_node;
   logic       mem_we;
   node_type   mem_waddr;
   logic       err;

   assign req_node   = req_tdata[NODE_W-1:0];
   // execute only when the output register is free or being emptied
   assign exec_fire  = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff || exec_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign succ_rd    = fwd_ff ? fwd_data_ff : mem_rd_ff;

   // execute step: one acquire or release against the lock state
   always_comb begin
      tail_valid_in = tail_valid_ff;
      tail_node_in  = tail_node_ff;
      holder_in     = holder_ff;
      succ_valid_in = succ_valid_ff;
      queued_in     = queued_ff;
      mem_we        = 1'b0;
      mem_waddr     = tail_node_ff;
      rsp_in        = '{status: ST_ERROR, grant_valid: 1'b0, grant_node: '0};
      err           = 1'b0;
      if (kind_ff == KIND_ACQUIRE) begin
         // repeated acquire by the holder or a waiting node
         err = (tail_valid_ff && holder_ff == node_ff) || queued_ff[node_ff];
      end else begin
         // release while free or by a node other than the holder
         err = !tail_valid_ff || holder_ff != node_ff;
      end
      if (exec_fire && !err) begin
         if (kind_ff == KIND_ACQUIRE) begin
            succ_valid_in[node_ff] = 1'b0;
            if (!tail_valid_ff) begin
               tail_valid_in = 1'b1;
               tail_node_in  = node_ff;
               holder_in     = node_ff;
               rsp_in        = '{status: ST_GRANTED, grant_valid: 1'b1, grant_node: node_ff};
            end else begin
               // swap into the tail and link behind the old tail in one step
               succ_valid_in[tail_node_ff] = 1'b1;
               mem_we                      = 1'b1;
               queued_in[node_ff]          = 1'b1;
               tail_node_in                = node_ff;
               rsp_in = '{status: ST_QUEUED, grant_valid: 1'b0, grant_node: '0};
            end
         end else begin
            if (succ_valid_ff[node_ff]) begin
               succ_valid_in[node_ff] = 1'b0;
               queued_in[succ_rd]     = 1'b0;
               holder_in              = succ_rd;
               rsp_in = '{status: ST_HANDED, grant_valid: 1'b1, grant_node: succ_rd};
            end else begin
               tail_valid_in = 1'b0;
               rsp_in = '{status: ST_FREED, grant_valid: 1'b0, grant_node: '0};
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (exec_fire) begin
         busy_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end
      // a link written now to the entry being read must bypass the memory
      fwd_in = mem_we && (mem_waddr == req_node);
   end

   // successor memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         succ_mem[mem_waddr] <= node_ff;
      end
      if (req_fire) begin
         mem_rd_ff   <= succ_mem[req_node];
         fwd_ff      <= fwd_in;
         fwd_data_ff <= node_ff;
         kind_ff     <= req_tuser;
         node_ff     <= req_node;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tail_valid_ff <= 1'b0;
         tail_node_ff  <= '0;
         holder_ff     <= '0;
         succ_valid_ff <= '0;
         queued_ff     <= '0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         tail_valid_ff <= tail_valid_in;
         tail_node_ff  <= tail_node_in;
         holder_ff     <= holder_in;
         succ_valid_ff <= succ_valid_in;
         queued_ff     <= queued_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - NODE_W - 4){1'b0}}, rsp_ff.grant_node,
                        rsp_ff.grant_valid, rsp_ff.status};

   // a grant only comes from an immediate grant or a hand-over
   `MQLM_ASSERT_IMPLY(a_grant_status, clock, reset, rsp_tvalid && rsp_ff.grant_valid,
      rsp_ff.status == ST_GRANTED || rsp_ff.status == ST_HANDED)
   // no node waits while the lock is free
   `MQLM_ASSERT_IMPLY(a_free_no_waiters, clock, reset, !tail_valid_ff, queued_ff == '0)
   // every executed item lands in the output register
   `MQLM_ASSERT_NEXT(a_exec_result, clock, reset, exec_fire, rsp_valid_ff)
   // a stalled output holds the pending item back
   `MQLM_ASSERT_NEXT(a_stall_holds, clock, reset, busy_ff && rsp_valid_ff && !rsp_tready,
      busy_ff)

endmodule
